>>> hdl/lrs_pkg.sv
// Package of types, constants and the sigmoid table for the logistic regression block.
package lrs_pkg;

  localparam int ACC_BITS = 48;
  localparam int PROB_BITS = 16;
  localparam int LR_BITS = 16;
  localparam int FRAC_BITS = 24;
  localparam logic [PROB_BITS-1:0] SIG_FAR = 16'd65514;
  localparam logic [PROB_BITS-1:0] PROB_HALF = 16'd32768;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_TRAIN = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic [PROB_BITS-1:0] prob_t;

  // Sigmoid breakpoints g(k) for k = 0..8 in Q0.16.
  function automatic logic [PROB_BITS-1:0] sig_tab(input logic [3:0] k);
    logic [PROB_BITS-1:0] g;
    case (k)
      4'd0: g = 16'd32768;
      4'd1: g = 16'd47911;
      4'd2: g = 16'd57724;
      4'd3: g = 16'd62428;
      4'd4: g = 16'd64357;
      4'd5: g = 16'd65097;
      4'd6: g = 16'd65374;
      4'd7: g = 16'd65476;
      default: g = 16'd65514;
    endcase
    return g;
  endfunction

  // Saturate a wide signed value to the accumulator range.
  function automatic acc_t sat_acc(input logic signed [ACC_BITS+1:0] v);
    acc_t hi;
    acc_t lo;
    hi = {1'b0, {(ACC_BITS-1){1'b1}}};
    lo = {1'b1, {(ACC_BITS-1){1'b0}}};
    if (v > $signed({{2{hi[ACC_BITS-1]}}, hi})) return hi;
    else if (v < $signed({{2{lo[ACC_BITS-1]}}, lo})) return lo;
    else return v[ACC_BITS-1:0];
  endfunction

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic acc_en;
    logic upd_en;
    logic ypos;
  } lane_ctl_t;

endpackage

>>> hdl/lrs_lane.sv
// One lane: product of a weight and a feature, and the signed weight update.
module lrs_lane #(
  parameter int WEIGHT_BITS = 32,
  parameter int FEATURE_BITS = 8
) (
  input  logic                                clk,
  input  lrs_pkg::lane_ctl_t                  ctl,
  input  logic signed [WEIGHT_BITS-1:0]       weight,
  input  logic [FEATURE_BITS-1:0]             feature,
  input  logic [31:0]                         dmag,
  output lrs_pkg::acc_t                       product,
  output logic signed [WEIGHT_BITS-1:0]       weight_new
);
  import lrs_pkg::*;

  localparam int PW = WEIGHT_BITS + FEATURE_BITS + 1;
  localparam int DW = 32 + FEATURE_BITS + 1;
  localparam int SW = (DW > WEIGHT_BITS ? DW : WEIGHT_BITS) + 2;

  logic signed [PW-1:0] prod_full;
  logic signed [DW-1:0] delta;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] w_hi;
  logic signed [SW-1:0] w_lo;

  // Register the product so the accumulator add sits in the next cycle.
  assign prod_full = weight * $signed({1'b0, feature});
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      product <= sat_acc((ACC_BITS+2)'(prod_full));
    end
  end

  // Update: weight plus or minus dmag times the stored feature, saturated.
  assign delta = $signed({1'b0, dmag}) * $signed({1'b0, feature});
  assign sum = ctl.ypos ? SW'(weight) + SW'(delta) : SW'(weight) - SW'(delta);
  assign w_hi = SW'({1'b0, {(WEIGHT_BITS-1){1'b1}}});
  assign w_lo = -w_hi - SW'(1);
  always_comb begin
    if (!ctl.upd_en) weight_new = weight;
    else if (sum > w_hi) weight_new = w_hi[WEIGHT_BITS-1:0];
    else if (sum < w_lo) weight_new = w_lo[WEIGHT_BITS-1:0];
    else weight_new = sum[WEIGHT_BITS-1:0];
  end
endmodule

>>> hdl/lrs_sigmoid.sv
// Piecewise-linear sigmoid over the saturated logit, registered result.
module lrs_sigmoid (
  input  logic          clk,
  input  logic          en,
  input  lrs_pkg::acc_t z,
  output lrs_pkg::prob_t p
);
  import lrs_pkg::*;

  logic [ACC_BITS-1:0] mag;
  logic [3:0] k;
  logic [FRAC_BITS-1:0] frac;
  logic [PROB_BITS-1:0] g0;
  logic [PROB_BITS-1:0] diff;
  logic [PROB_BITS+FRAC_BITS-1:0] interp;
  logic [PROB_BITS-1:0] g;

  // Magnitude, segment and fraction; segments from eight on are flat.
  assign mag = z[ACC_BITS-1] ? ACC_BITS'(-z) : ACC_BITS'(z);
  assign k = (mag[ACC_BITS-1:FRAC_BITS+3] != '0) ? 4'd8 : {1'b0, mag[FRAC_BITS+2:FRAC_BITS]};
  assign frac = mag[FRAC_BITS-1:0];
  assign g0 = sig_tab(k);
  assign diff = sig_tab(k + 4'd1) - g0;
  assign interp = diff * frac;
  assign g = (k == 4'd8) ? SIG_FAR : g0 + interp[PROB_BITS+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) p <= z[ACC_BITS-1] ? PROB_BITS'(17'h10000 - {1'b0, g}) : g;
  end
endmodule

>>> hdl/logistic_regression_sgd.sv
// Top level of the logistic regression classifier with stochastic gradient training.
// Each feature group is taken in S_IN with its lane products registered, and the products
// are merged into the logit in S_ACC. A last group then passes S_BIAS, where the sigmoid
// registers its result, and S_SIG, where the update step is formed, before S_OUT loads the
// result. A train pass also walks the weights LANES at a time in S_UPD and then updates the
// bias in S_BUPD. Weight writes and ignored opcodes are handled in S_IN alone. Loading the
// result waits while an earlier result is still uncollected; once loaded, the next item is
// taken while the result waits to be collected.
module logistic_regression_sgd #(
  parameter int NUM_FEATURES = 64,
  parameter int LANES = 4,
  parameter int WEIGHT_BITS = 32,
  parameter int FEATURE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  feature_a,
  input  logic [7:0]  feature_b,
  input  logic [7:0]  feature_c,
  input  logic [7:0]  feature_d,
  input  logic        last_group,
  input  logic        target_positive,
  input  logic [6:0]  weight_index,
  input  logic signed [31:0] weight_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        predicted_positive,
  output logic [15:0] probability,
  output logic        trained
);
  import lrs_pkg::*;

  localparam int NG = (NUM_FEATURES + LANES - 1) / LANES;
  localparam int GB = (NG > 1) ? $clog2(NG) : 1;
  localparam int CB = $clog2(NG + 1);
  localparam int WB = WEIGHT_BITS;
  localparam int FB = FEATURE_BITS;
  localparam int BSW = (WB > 32 ? WB : 32) + 2;

  typedef enum logic [2:0] {S_IN, S_ACC, S_BIAS, S_SIG, S_UPD, S_BUPD, S_OUT} state_t;

  state_t state;
  logic [15:0] learn_rate;
  logic signed [WB-1:0] wmem [LANES][NG];
  logic [FB-1:0] smem [LANES][NG];
  logic signed [WB-1:0] bias;
  acc_t logit_sum;
  acc_t z;
  logic [CB-1:0] group_count;
  logic [GB-1:0] upd_grp;
  logic train;
  logic ypos;
  logic last;
  logic [31:0] dmag;
  lane_ctl_t ctl;
  logic signed [WB-1:0] lw [LANES];
  logic [FB-1:0] lf [LANES];
  logic [FB-1:0] in_f [LANES];
  acc_t prod [LANES];
  logic signed [WB-1:0] lw_new [LANES];
  prob_t p;
  logic accept;
  logic [GB-1:0] cur_grp;
  logic in_range;
  logic signed [BSW-1:0] bsum;
  logic signed [BSW-1:0] b_hi;
  logic signed [WB-1:0] wsat;
  logic [31:0] err;
  logic [47:0] dprod;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IN);
  assign cur_grp = group_count[GB-1:0];
  assign in_range = (group_count < CB'(NG));

  // Features of the current item per lane; lanes beyond four read zero.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (l)
        0: in_f[l] = FB'(feature_a);
        1: in_f[l] = FB'(feature_b);
        2: in_f[l] = FB'(feature_c);
        3: in_f[l] = FB'(feature_d);
        default: in_f[l] = '0;
      endcase
    end
  end

  // Saturate a written weight value to WEIGHT_BITS.
  always_comb begin
    logic signed [47:0] wv;
    logic signed [47:0] whi;
    wv = 48'(weight_value);
    whi = 48'({1'b0, {(WB-1){1'b1}}});
    if (wv > whi) wsat = whi[WB-1:0];
    else if (wv < -whi - 48'sd1) wsat = WB'(-whi - 48'sd1);
    else wsat = wv[WB-1:0];
  end

  // Lane operands: the current group during accumulation, the walked group in update.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lw[l] = wmem[l][(state == S_UPD) ? upd_grp : cur_grp];
      lf[l] = (state == S_UPD) ? smem[l][upd_grp] : in_f[l];
    end
  end

  assign ctl.acc_en = accept && (opcode == OP_PREDICT || opcode == OP_TRAIN) && in_range;
  assign ctl.upd_en = (state == S_UPD);
  assign ctl.ypos = ypos;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lrs_lane #(.WEIGHT_BITS(WB), .FEATURE_BITS(FB)) u_lane (
      .clk(clk), .ctl(ctl), .weight(lw[l]), .feature(lf[l]), .dmag(dmag),
      .product(prod[l]), .weight_new(lw_new[l])
    );
  end

  lrs_sigmoid u_sig (.clk(clk), .en(state == S_BIAS), .z(z), .p(p));

  assign err = ypos ? 32'h10000 - 32'(p) : 32'(p);
  assign dprod = 48'(learn_rate) * 48'(err);
  assign b_hi = BSW'({1'b0, {(WB-1){1'b1}}});
  assign bsum = ypos ? BSW'(bias) + BSW'(dmag) : BSW'(bias) - BSW'(dmag);

  // Weight and sample stores, one row of LANES entries per group.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (ctl.acc_en) smem[l][cur_grp] <= in_f[l];
    end
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        for (int g = 0; g < NG; g++) wmem[l][g] <= '0;
      end
    end else if (state == S_UPD) begin
      for (int l = 0; l < LANES; l++) begin
        if ((GB+1)'(upd_grp) * LANES + l < NUM_FEATURES && CB'(upd_grp) < group_count)
          wmem[l][upd_grp] <= lw_new[l];
      end
    end else if (accept && opcode == OP_WRITE) begin
      // Decode the written index onto its lane and group.
      for (int l = 0; l < LANES; l++) begin
        for (int g = 0; g < NG; g++) begin
          if (g * LANES + l < NUM_FEATURES && weight_index == 7'(g * LANES + l))
            wmem[l][g] <= wsat;
        end
      end
    end
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      learn_rate <= 16'd655;
      bias <= '0;
      logit_sum <= '0;
      group_count <= '0;
      out_valid <= 1'b0;
      upd_grp <= '0;
      last <= 1'b0;
    end else begin
      if (cfg_we) learn_rate <= cfg_wdata;
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IN: if (accept) begin
          if (opcode == OP_WRITE) begin
            if (weight_index == 7'(NUM_FEATURES)) bias <= wsat;
          end else if (opcode != OP_NONE) begin
            last <= last_group;
            train <= (opcode == OP_TRAIN);
            ypos <= target_positive;
            if (in_range) begin
              group_count <= group_count + CB'(1);
              state <= S_ACC;
            end else if (last_group) begin
              state <= S_BIAS;
              z <= sat_acc((ACC_BITS+2)'(logit_sum) + (ACC_BITS+2)'(bias));
            end
          end
        end
        S_ACC: begin
          acc_t s;
          s = logit_sum;
          for (int l = 0; l < LANES; l++)
            s = sat_acc((ACC_BITS+2)'(s) + (ACC_BITS+2)'(prod[l]));
          logit_sum <= s;
          z <= sat_acc((ACC_BITS+2)'(s) + (ACC_BITS+2)'(bias));
          state <= last ? S_BIAS : S_IN;
        end
        S_BIAS: state <= S_SIG;
        S_SIG: begin
          dmag <= 32'(dprod >> 8);
          upd_grp <= '0;
          state <= train ? S_UPD : S_OUT;
        end
        S_UPD: begin
          upd_grp <= upd_grp + GB'(1);
          if (upd_grp == GB'(NG - 1)) state <= S_BUPD;
        end
        S_BUPD: begin
          if (bsum > b_hi) bias <= b_hi[WB-1:0];
          else if (bsum < -b_hi - BSW'(1)) bias <= WB'(-b_hi - BSW'(1));
          else bias <= bsum[WB-1:0];
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          predicted_positive <= (p > PROB_HALF);
          probability <= p;
          trained <= train;
          logit_sum <= '0;
          group_count <= '0;
          state <= S_IN;
        end
        default: state <= S_IN;
      endcase
    end
  end
endmodule

>>> hdl/lrs_checker.sv
// Port-level checks for the logistic regression block, bound to the top level.
module lrs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] probability,
  input logic predicted_positive
);
  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(probability))
    else $error("result changed while stalled");

  // The sign follows the probability.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> predicted_positive == (probability > 16'd32768))
    else $error("sign does not match probability");

  // No output after reset.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // Handshake lines are always driven out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid, out_ready}))
    else $error("unknown handshake level");
endmodule

bind logistic_regression_sgd lrs_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .probability(probability),
  .predicted_positive(predicted_positive)
);

>>> sim/logistic_regression_sgd_tb.sv
// Self-checking testbench for the logistic regression classifier with gradient training.
module logistic_regression_sgd_tb;
  import lrs_pkg::*;

  localparam int NFEAT = 64;
  localparam int NGRP = 16;
  localparam logic [6:0] BIAS_IDX = 7'd64;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0] op;
    logic [7:0] fa, fb, fc, fd;
    logic last, tgt;
    logic [6:0] idx;
    logic signed [31:0] val;
    bit chk;
    logic e_pred;
    logic [15:0] e_prob;
    logic e_trn;
  } item_t;

  typedef struct {
    logic pred;
    logic [15:0] prob;
    logic trn;
  } verdict_t;

  // One row of the directed table: reps copies, last_group only on the final copy.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] fa, fb, fc, fd;
    logic last, tgt;
    logic [6:0] idx;
    logic [31:0] val;
    logic [4:0] reps;
    logic chk, e_pred;
    logic [15:0] e_prob;
    logic e_trn;
  } row_t;

  localparam int NROWS = 18;
  row_t dir_tab [NROWS] = '{
    '{OP_PREDICT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 7'd0, 32'h0, 5'd1,
      1'b1, 1'b0, 16'd32768, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, BIAS_IDX, 32'h7FFFFFFF, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_PREDICT, 8'h0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0, 7'd0, 32'h0, 5'd1,
      1'b1, 1'b1, 16'd65514, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, BIAS_IDX, 32'h80000000, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_PREDICT, 8'h0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0, 7'd0, 32'h0, 5'd1,
      1'b1, 1'b0, 16'd22, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, 7'd65, 32'h7FFFFFFF, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, 7'd127, 32'h01000000, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 7'd0, 32'h0, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_PREDICT, 8'h0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0, 7'd0, 32'h0, 5'd1,
      1'b1, 1'b0, 16'd22, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, BIAS_IDX, 32'h0, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, 7'd0, 32'h01000000, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_WRITE, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b0, 7'd63, 32'h80000000, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_TRAIN, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1, 1'b1, 7'd0, 32'h0, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_PREDICT, 8'd9, 8'd80, 8'd7, 8'd255, 1'b0, 1'b0, 7'd0, 32'h0, 5'd3,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_TRAIN, 8'd5, 8'd6, 8'd7, 8'd8, 1'b1, 1'b0, 7'd0, 32'h0, 5'd1,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_PREDICT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 7'd0, 32'h0, 5'd20,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_TRAIN, 8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1, 1'b1, 7'd0, 32'h0, 5'd16,
      1'b0, 1'b0, 16'd0, 1'b0},
    '{OP_TRAIN, 8'h00, 8'hFF, 8'h01, 8'h7F, 1'b1, 1'b0, 7'd0, 32'h0, 5'd16,
      1'b0, 1'b0, 16'd0, 1'b0}
  };

  logic clk, rst;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] opcode;
  logic [7:0] feature_a, feature_b, feature_c, feature_d;
  logic last_group, target_positive;
  logic [6:0] weight_index;
  logic signed [31:0] weight_value;
  logic out_valid, out_ready;
  logic predicted_positive;
  logic [15:0] probability;
  logic trained;

  logistic_regression_sgd u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .feature_a(feature_a), .feature_b(feature_b), .feature_c(feature_c),
    .feature_d(feature_d), .last_group(last_group), .target_positive(target_positive),
    .weight_index(weight_index), .weight_value(weight_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .predicted_positive(predicted_positive), .probability(probability), .trained(trained)
  );

  // Model state of the classifier.
  longint model_w [NFEAT] = '{default: 0};
  longint model_bias = 0;
  longint model_logit = 0;
  logic [7:0] model_store [NFEAT];
  int model_groups = 0;
  logic [15:0] model_rate;

  item_t send_q[$];
  item_t cur_item;
  verdict_t pending_verdicts[$];
  int errors = 0;
  int cycles = 0;
  int verdicts_seen = 0;
  int trains_seen = 0;
  int groups_sent;
  bit calm;

  function automatic longint sat_weight(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_logit(longint v);
    longint hi;
    hi = 64'sh7FFFFFFFFFFF;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Piecewise-linear sigmoid over |z| in Q.24, mirrored for negative z.
  function automatic logic [15:0] sigmoid_q16(longint z);
    longint mag;
    longint k;
    longint g;
    mag = z < 0 ? -z : z;
    k = mag >>> 24;
    if (k >= 8) g = SIG_FAR;
    else g = sig_tab(k[3:0]) +
             (((sig_tab(k[3:0] + 4'd1) - sig_tab(k[3:0])) * (mag & 64'hFFFFFF)) >>> 24);
    return z < 0 ? 16'(17'd65536 - g[16:0]) : g[15:0];
  endfunction

  // Advances the model by one accepted item; reports a verdict on the last group.
  task automatic classify_item(input item_t it, output bit got, output verdict_t v);
    logic [7:0] lanes [4];
    int filled;
    longint z, dmag, d;
    logic [16:0] err;
    logic [15:0] p;
    got = 0;
    v = '{1'b0, 16'd0, 1'b0};
    lanes = '{it.fa, it.fb, it.fc, it.fd};
    if (it.op == OP_NONE) return;
    if (it.op == OP_WRITE) begin
      if (it.idx < NFEAT) model_w[it.idx] = sat_weight(longint'(it.val));
      else if (it.idx == BIAS_IDX) model_bias = sat_weight(longint'(it.val));
      return;
    end
    if (model_groups < NGRP) begin
      for (int l = 0; l < 4; l++) begin
        model_store[model_groups*4 + l] = lanes[l];
        model_logit = sat_logit(model_logit +
                                sat_logit(model_w[model_groups*4 + l] * longint'(lanes[l])));
      end
      model_groups++;
    end
    if (!it.last) return;
    filled = model_groups * 4;
    z = sat_logit(model_logit + model_bias);
    p = sigmoid_q16(z);
    if (it.op == OP_TRAIN) begin
      err = it.tgt ? 17'd65536 - p : {1'b0, p};
      dmag = (longint'(model_rate) * longint'(err)) >>> 8;
      for (int i = 0; i < filled; i++) begin
        d = dmag * longint'(model_store[i]);
        model_w[i] = sat_weight(it.tgt ? model_w[i] + d : model_w[i] - d);
      end
      model_bias = sat_weight(it.tgt ? model_bias + dmag : model_bias - dmag);
    end
    model_logit = 0;
    model_groups = 0;
    got = 1;
    v = '{p > PROB_HALF, p, it.op == OP_TRAIN};
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Input side: the model is advanced on each accepted item, then the next is offered.
  always @(posedge clk) begin
    bit got;
    verdict_t v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        classify_item(cur_item, got, v);
        if (got) begin
          if (cur_item.chk) v = '{cur_item.e_pred, cur_item.e_prob, cur_item.e_trn};
          pending_verdicts.insert(pending_verdicts.size(), v);
        end
      end
      if (!in_valid || in_ready) begin
        if (send_q.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
          cur_item = send_q.pop_front();
          in_valid <= 1'b1;
          opcode <= cur_item.op;
          feature_a <= cur_item.fa;
          feature_b <= cur_item.fb;
          feature_c <= cur_item.fc;
          feature_d <= cur_item.fd;
          last_group <= cur_item.last;
          target_positive <= cur_item.tgt;
          weight_index <= cur_item.idx;
          weight_value <= cur_item.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure and comparison against the oldest verdict.
  always @(posedge clk) begin
    verdict_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, pending_verdicts.size());
      $display("logistic_regression_sgd verification failed");
      $finish;
    end
    out_ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 31);
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (trained) trains_seen++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected item prob=%0d pred=%0b trained=%0b",
                 $time, probability, predicted_positive, trained);
      end else begin
        e = pending_verdicts.pop_front();
        if (probability !== e.prob || predicted_positive !== e.pred || trained !== e.trn) begin
          errors++;
          $display("%0t: mismatch expected prob=%0d pred=%0b trained=%0b, got %0d %0b %0b",
                   $time, e.prob, e.pred, e.trn, probability, predicted_positive, trained);
        end
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic last, input logic tgt,
                            input logic [6:0] idx, input logic signed [31:0] val);
    item_t it;
    int mode;
    mode = $urandom_range(3);
    it.op = op;
    it.fa = mode == 0 ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    it.fb = 8'($urandom_range(255));
    it.fc = mode == 1 ? 8'hFF : 8'($urandom_range(255));
    it.fd = 8'($urandom_range(255));
    it.last = last;
    it.tgt = tgt;
    it.idx = idx;
    it.val = val;
    it.chk = 0;
    if (op == OP_PREDICT || op == OP_TRAIN) groups_sent++;
    send_q.insert(send_q.size(), it);
  endtask

  // A weight write, usually small so that the logit stays in the sigmoid's slope.
  task automatic queue_write(input bit stray);
    logic [6:0] idx;
    logic signed [31:0] val;
    idx = stray ? 7'($urandom_range(127)) : 7'($urandom_range(64));
    val = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(1 << 20)) - (1 << 19);
    queue_item(OP_WRITE, 1'b0, 1'b0, idx, val);
  endtask

  // A sample: mostly sixteen groups, sometimes short or overlong, with occasional noise.
  task automatic queue_sample();
    int n;
    logic [1:0] op_last;
    n = $urandom_range(99) < 75 ? NGRP : $urandom_range(1, 20);
    op_last = $urandom_range(1) ? OP_TRAIN : OP_PREDICT;
    for (int g = 0; g < n; g++) begin
      if ($urandom_range(99) < 4) queue_write(1'b1);
      if ($urandom_range(99) < 3)
        queue_item(OP_NONE, 1'($urandom_range(1)), 1'b1, 7'd0, 32'sd0);
      queue_item(g == n - 1 ? op_last : logic'($urandom_range(1)) ? OP_TRAIN : OP_PREDICT,
                 g == n - 1, 1'($urandom_range(1)), 7'($urandom_range(127)), $urandom);
    end
  endtask

  task automatic wait_idle();
    while (send_q.size() > 0 || in_valid || pending_verdicts.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] rate);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= rate;
    model_rate = rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] rates [8];
    item_t it;
    rates = '{16'd0, 16'd65535, 16'd655, 16'd1, 16'd4096, 16'd300, 16'd32768, 16'd655};
    model_rate = 16'd655;
    groups_sent = 0;
    calm = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run at the reset learning rate.
    for (int r = 0; r < NROWS; r++) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        it = '{dir_tab[r].op, dir_tab[r].fa, dir_tab[r].fb, dir_tab[r].fc, dir_tab[r].fd,
               dir_tab[r].last && k == dir_tab[r].reps - 1, dir_tab[r].tgt, dir_tab[r].idx,
               dir_tab[r].val, dir_tab[r].chk, dir_tab[r].e_pred, dir_tab[r].e_prob,
               dir_tab[r].e_trn};
        send_q.insert(send_q.size(), it);
      end
    end
    wait_idle();

    // Random phases, each at its own learning rate; one phase runs without any idling.
    for (int ph = 0; ph < 8; ph++) begin
      write_rate(ph < 7 ? rates[ph] : 16'($urandom_range(65535)));
      calm = (ph == 3);
      groups_sent = 0;
      while (groups_sent < 200) begin
        if ($urandom_range(99) < 15) begin
          for (int w = $urandom_range(1, 4); w > 0; w--) queue_write(1'b0);
        end
        queue_sample();
        while (send_q.size() > 40) @(posedge clk);
      end
      wait_idle();
    end

    $display("Ran the directed table and eight learning-rate phases: %0d verdicts, %0d trained.",
             verdicts_seen, trains_seen);
    if (errors == 0) begin
      $display("logistic_regression_sgd verification clean");
    end else begin
      $display("logistic_regression_sgd verification failed");
    end
    $finish;
  end

endmodule

>>> logistic_regression_sgd.f
hdl/lrs_pkg.sv
hdl/lrs_lane.sv
hdl/lrs_sigmoid.sv
hdl/logistic_regression_sgd.sv
hdl/lrs_checker.sv
sim/logistic_regression_sgd_tb.sv
